// File: design/dvrt_pkg.sv
// Shared types, constants and codes for the distance-vector route table.
package dvrt_pkg;

  localparam int NODES_DEF = 16;

  localparam int NODE_W = 4;
  localparam int HOP_W  = 5;
  localparam int COST_W = 20;
  localparam int TIME_W = 16;
  localparam int OP_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [HOP_W-1:0]  NO_HOP        = 5'd16;
  localparam logic [COST_W-1:0] INF_RESET     = 20'd1000000;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INFINITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_LINK    = 3'd0,
    OP_CHANGE_COST = 3'd1,
    OP_ADVERT      = 3'd2,
    OP_TICK        = 3'd3,
    OP_QUERY       = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_LINK,
    CLS_ADV_HEAR,
    CLS_ADV,
    CLS_TICK,
    CLS_QUERY
  } item_cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV_WR,
    ST_TICK_RD,
    ST_TICK_HOP,
    ST_TICK_EMIT,
    ST_QRY_EMIT
  } state_e;

  typedef struct packed {
    logic [HOP_W-1:0]  next;
    logic [COST_W-1:0] cost;
  } route_ent_t;

  typedef struct packed {
    logic link_wr;
    logic adv_rd;
    logic adv_wr;
    logic tick_start;
    logic tick_rd;
    logic tick_hop;
    logic tick_emit;
    logic qry_rd;
    logic qry_emit;
  } cmd_t;

  typedef struct packed {
    item_cls_e cls;
    logic      out_free;
    logic      last_entry;
  } status_t;

endpackage

// File: design/dvrt_ctrl.sv
// Controller state machine that sequences item handling and the tick walk.
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.cls)
            CLS_ADV:   state_d = ST_ADV_WR;
            CLS_TICK:  state_d = ST_TICK_RD;
            CLS_QUERY: state_d = ST_QRY_EMIT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADV_WR:   state_d = ST_IDLE;
      ST_TICK_RD:  state_d = ST_TICK_HOP;
      ST_TICK_HOP: state_d = ST_TICK_EMIT;
      ST_TICK_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_entry ? ST_IDLE : ST_TICK_RD;
        end
      end
      ST_QRY_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (status_i.cls)
            CLS_LINK:     cmd_o.link_wr    = 1'b1;
            CLS_ADV_HEAR: cmd_o.adv_rd     = 1'b1;
            CLS_ADV:      cmd_o.adv_rd     = 1'b1;
            CLS_TICK:     cmd_o.tick_start = 1'b1;
            CLS_QUERY:    cmd_o.qry_rd     = 1'b1;
            default:      cmd_o            = '0;
          endcase
        end
      end
      ST_ADV_WR:    cmd_o.adv_wr   = 1'b1;
      ST_TICK_RD:   cmd_o.tick_rd  = 1'b1;
      ST_TICK_HOP:  cmd_o.tick_hop = 1'b1;
      ST_TICK_EMIT: cmd_o.tick_emit = status_i.out_free;
      ST_QRY_EMIT:  cmd_o.qry_emit  = status_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

endmodule

// File: design/dvrt_datapath.sv
// Route, link and heard-time tables with configuration and the result register.
module dvrt_datapath
  import dvrt_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [NODE_W-1:0]     node_i,
  input  logic [NODE_W-1:0]     dest_i,
  input  logic [HOP_W-1:0]      adv_next_hop_i,
  input  logic [COST_W-1:0]     cost_i,
  input  logic [TIME_W-1:0]     tick_time_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [NODE_W-1:0]     route_dest_o,
  output logic [HOP_W-1:0]      route_next_o,
  output logic [COST_W-1:0]     route_cost_o,
  output logic                  reachable_o,
  output logic                  last_of_dump_o
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int XW = (IW + 1 > HOP_W) ? IW + 1 : HOP_W;

  // Configuration registers.
  logic [NODE_W-1:0] my_node_q;
  logic [COST_W-1:0] inf_q;
  logic [TIME_W-1:0] timeout_q;
  logic [TIME_W-1:0] now_q;
  logic              tables_clr;

  assign tables_clr = cfg_we_i && (cfg_index_i == CFG_MY_NODE || cfg_index_i == CFG_INFINITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_node_q <= '0;
      inf_q     <= INF_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MY_NODE:  my_node_q <= cfg_data_i[NODE_W-1:0];
        CFG_INFINITY: inf_q     <= cfg_data_i;
        CFG_TIMEOUT:  timeout_q <= cfg_data_i[TIME_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input decode.
  logic [XW-1:0]     my_x, node_x, dest_x, tgt_x, nodes_x;
  logic [NODE_W-1:0] tgt;
  logic              link_ok, adv_ok, dest_ok;
  item_cls_e         cls;

  assign my_x    = XW'(my_node_q);
  assign node_x  = XW'(node_i);
  assign dest_x  = XW'(dest_i);
  assign nodes_x = XW'(NODES);
  assign tgt     = (node_i != my_node_q) ? node_i : dest_i;
  assign tgt_x   = XW'(tgt);
  assign link_ok = (tgt != my_node_q) && (tgt_x < nodes_x);
  assign adv_ok  = (node_i != my_node_q) && (node_x < nodes_x);
  assign dest_ok = dest_x < nodes_x;

  always_comb begin
    unique case (op_i)
      OP_ADD_LINK, OP_CHANGE_COST: cls = link_ok ? CLS_LINK : CLS_NONE;
      OP_ADVERT: begin
        if (!adv_ok) begin
          cls = CLS_NONE;
        end else begin
          cls = dest_ok ? CLS_ADV : CLS_ADV_HEAR;
        end
      end
      OP_TICK:  cls = CLS_TICK;
      OP_QUERY: cls = CLS_QUERY;
      default:  cls = CLS_NONE;
    endcase
  end

  // Item registers.
  logic [NODE_W-1:0] node_q, dest_q;
  logic [HOP_W-1:0]  nh_q;
  logic [COST_W-1:0] cost_q;
  logic              dest_ok_q;
  logic [IW-1:0]     idx_q;
  logic              last_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv_rd || cmd_i.qry_rd) begin
      node_q    <= node_i;
      dest_q    <= dest_i;
      nh_q      <= adv_next_hop_i;
      cost_q    <= cost_i;
      dest_ok_q <= dest_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.tick_start) begin
      now_q <= tick_time_i;
      idx_q <= '0;
    end else if (cmd_i.tick_emit) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  assign last_entry = (idx_q == IW'(NODES - 1));

  // Neighbor tracking bits and heard times.
  logic [NODES-1:0] nb_q;
  logic [TIME_W-1:0] lh_mem [NODES];
  logic              hear_we;
  logic [IW-1:0]     hear_wa;

  assign hear_we = (cmd_i.link_wr && op_i == OP_ADD_LINK) || cmd_i.adv_rd;
  assign hear_wa = cmd_i.link_wr ? tgt_x[IW-1:0] : node_x[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q <= '0;
    end else if (tables_clr) begin
      nb_q <= '0;
    end else if (hear_we) begin
      nb_q[hear_wa] <= 1'b1;
    end
  end

  // Link cost table; an entry that was never written reads as its reset value.
  logic [COST_W-1:0] nc_mem [NODES];
  logic [NODES-1:0]  nc_vld_q;
  logic [COST_W-1:0] nc_rd_q;
  logic              nc_vld_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_vld_q <= '0;
    end else if (tables_clr) begin
      nc_vld_q <= '0;
    end else if (cmd_i.link_wr) begin
      nc_vld_q[tgt_x[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr) begin
      nc_mem[tgt_x[IW-1:0]] <= cost_i;
    end
    if (hear_we) begin
      lh_mem[hear_wa] <= now_q;
    end
    if (cmd_i.adv_rd) begin
      nc_rd_q     <= nc_mem[node_x[IW-1:0]];
      nc_vld_rd_q <= nc_vld_q[node_x[IW-1:0]];
    end
  end

  // Route table with one read port and one write port.
  route_ent_t       best_mem [NODES];
  logic [NODES-1:0] best_vld_q;
  route_ent_t       best_rd_q;
  logic             best_vld_rd_q;
  logic [IW-1:0]    best_ra, best_ra_q;
  logic             best_re;
  logic             best_we;
  logic [IW-1:0]    best_wa;
  route_ent_t       best_wd;

  assign best_re = cmd_i.adv_rd || cmd_i.qry_rd || cmd_i.tick_rd;
  assign best_ra = (cmd_i.adv_rd || cmd_i.qry_rd) ? dest_x[IW-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (best_we) begin
      best_mem[best_wa] <= best_wd;
    end
    if (best_re) begin
      best_rd_q     <= best_mem[best_ra];
      best_vld_rd_q <= best_vld_q[best_ra];
      best_ra_q     <= best_ra;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= '0;
    end else if (tables_clr) begin
      best_vld_q <= '0;
    end else if (best_we) begin
      best_vld_q[best_wa] <= 1'b1;
    end
  end

  // Entries as they stand, with reset contents for unwritten ones.
  logic              own_rd, own_nc;
  logic [COST_W-1:0] bc_eff, nc_eff;
  logic [HOP_W-1:0]  bn_eff;

  assign own_rd = (XW'(best_ra_q) == my_x);
  assign own_nc = (XW'(node_q) == my_x);
  assign bc_eff = best_vld_rd_q ? best_rd_q.cost : (own_rd ? '0 : inf_q);
  assign bn_eff = best_vld_rd_q ? best_rd_q.next : (own_rd ? HOP_W'(my_node_q) : NO_HOP);
  assign nc_eff = nc_vld_rd_q ? nc_rd_q : (own_nc ? '0 : inf_q);

  // Relaxation.
  logic [COST_W:0]   sum;
  logic              take;
  logic [COST_W-1:0] sum_sat;
  logic [XW-1:0]     dest_q_x;

  assign sum      = {1'b0, cost_q} + {1'b0, nc_eff};
  assign take     = (sum < {1'b0, bc_eff} && nh_q != HOP_W'(my_node_q))
                    || (bn_eff == HOP_W'(node_q));
  assign sum_sat  = (sum < {1'b0, inf_q}) ? sum[COST_W-1:0] : inf_q;
  assign dest_q_x = XW'(dest_q);

  // Tick walk: hop lookup and down test.
  route_ent_t        ent_q;
  logic              hop_ok_q;
  logic              nb_rd_q;
  logic [TIME_W-1:0] lh_rd_q;
  logic [XW-1:0]     hop_x, idx_x;
  logic [TIME_W-1:0] silent;
  logic              hop_down;

  assign hop_x = XW'(bn_eff);
  assign idx_x = XW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_hop) begin
      ent_q.cost <= bc_eff;
      ent_q.next <= bn_eff;
      hop_ok_q   <= (bn_eff != NO_HOP);
      nb_rd_q    <= nb_q[hop_x[IW-1:0]];
      lh_rd_q    <= lh_mem[hop_x[IW-1:0]];
    end
  end

  assign silent   = now_q - lh_rd_q;
  assign hop_down = hop_ok_q && nb_rd_q && (silent >= timeout_q) && (idx_x != my_x);

  always_comb begin
    best_we = 1'b0;
    best_wa = idx_q;
    best_wd = '{next: NO_HOP, cost: inf_q};
    if (cmd_i.adv_wr) begin
      best_we = take;
      best_wa = dest_q_x[IW-1:0];
      best_wd = '{next: HOP_W'(node_q), cost: sum_sat};
    end else if (cmd_i.tick_emit) begin
      best_we = hop_down;
    end
  end

  // Result register.
  logic              out_valid_q;
  logic [NODE_W-1:0] r_dest_q;
  logic [HOP_W-1:0]  r_next_q;
  logic [COST_W-1:0] r_cost_q;
  logic              r_last_q;
  logic              out_load;
  logic              out_free;

  assign out_load = cmd_i.tick_emit || cmd_i.qry_emit;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_emit) begin
      r_dest_q <= idx_x[NODE_W-1:0];
      r_next_q <= ent_q.next;
      r_cost_q <= ent_q.cost;
      r_last_q <= last_entry;
    end else if (cmd_i.qry_emit) begin
      r_dest_q <= dest_q;
      r_next_q <= dest_ok_q ? bn_eff : NO_HOP;
      r_cost_q <= dest_ok_q ? bc_eff : inf_q;
      r_last_q <= 1'b1;
    end
  end

  assign status_o = '{cls: cls, out_free: out_free, last_entry: last_entry};

  assign out_valid_o    = out_valid_q;
  assign route_dest_o   = r_dest_q;
  assign route_next_o   = r_next_q;
  assign route_cost_o   = r_cost_q;
  assign reachable_o    = r_cost_q < inf_q;
  assign last_of_dump_o = r_last_q;

endmodule

// File: design/distance_vector_route_table.sv
// Distance-vector route table: per-destination best cost and next hop, relaxed by
// neighbor advertisements, with link costs, neighbor liveness and a timed sweep.
// A link add or link cost change is written as it is taken; an advertisement
// entry reads the route and link tables, then writes back; a query reads the
// route table, then waits for the result register. A tick reads each entry
// through the single read port of the route table, then looks up the heard time
// of its next hop; it reports every entry in index order and drops a route through
// a silent neighbor as it reports that entry. Input is taken only between items;
// a finished result waits in an output register while the next item is accepted.
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [NODE_W-1:0]     node_i,
  input  logic [NODE_W-1:0]     dest_i,
  input  logic [HOP_W-1:0]      adv_next_hop_i,
  input  logic [COST_W-1:0]     cost_i,
  input  logic [TIME_W-1:0]     tick_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NODE_W-1:0]     route_dest_o,
  output logic [HOP_W-1:0]      route_next_o,
  output logic [COST_W-1:0]     route_cost_o,
  output logic                  reachable_o,
  output logic                  last_of_dump_o
);

  cmd_t    cmd;
  status_t status;

  dvrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dvrt_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .node_i         (node_i),
    .dest_i         (dest_i),
    .adv_next_hop_i (adv_next_hop_i),
    .cost_i         (cost_i),
    .tick_time_i    (tick_time_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .route_dest_o   (route_dest_o),
    .route_next_o   (route_next_o),
    .route_cost_o   (route_cost_o),
    .reachable_o    (reachable_o),
    .last_of_dump_o (last_of_dump_o)
  );

endmodule
